[rtl/dro_pkg.sv]
// Shared types, constants and the arctangent table of the odometry block.
package dro_pkg;

	// Rotation steps of the CORDIC, limited by the table depth.
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_DEPTH = 24;
	localparam int ROT_STEPS = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;
	localparam int ITER_W = $clog2(ROT_STEPS);

	// CORDIC vector width: 48-bit start magnitude, gain growth and sign.
	localparam int CX_W = 52;
	localparam int DX_W = CX_W - 16;

	// Inverse CORDIC gain, Q0.32.
	localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_SET_POSE = 1'b1;

	localparam logic [1:0] REG_DIST_DB = 2'd0;
	localparam logic [1:0] REG_ANG_DB = 2'd1;
	localparam logic [1:0] REG_CONF_RATE = 2'd2;

	typedef struct packed {
		logic opcode;
		logic signed [31:0] distance_reading;
		logic [15:0] angle_reading;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic [15:0] pose_heading;
	} dro_in_t;

	typedef struct packed {
		logic signed [31:0] x_position;
		logic signed [31:0] y_position;
		logic [15:0] heading_estimate;
		logic [31:0] uncertainty;
		logic [31:0] travelled;
	} dro_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULK,
		ST_PREP,
		ST_ROT,
		ST_MULC,
		ST_DONE
	} dro_state_t;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_SKIP,
		KIND_MOVE
	} dro_kind_t;

	typedef struct packed {
		logic load;
		logic step;
	} dro_cordic_ctl_t;

	// Arctangent of 2^-i, 2^32 units per turn.
	function automatic logic [31:0] dro_atan(input logic [4:0] idx);
		logic [31:0] val;
		unique case (idx)
			5'd0: val = 32'h20000000;
			5'd1: val = 32'h12E4051E;
			5'd2: val = 32'h09FB385B;
			5'd3: val = 32'h051111D4;
			5'd4: val = 32'h028B0D43;
			5'd5: val = 32'h0145D7E1;
			5'd6: val = 32'h00A2F61E;
			5'd7: val = 32'h00517C55;
			5'd8: val = 32'h0028BE53;
			5'd9: val = 32'h00145F2F;
			5'd10: val = 32'h000A2F98;
			5'd11: val = 32'h000517CC;
			5'd12: val = 32'h00028BE6;
			5'd13: val = 32'h000145F3;
			5'd14: val = 32'h0000A2FA;
			5'd15: val = 32'h0000517D;
			5'd16: val = 32'h000028BE;
			5'd17: val = 32'h0000145F;
			5'd18: val = 32'h00000A30;
			5'd19: val = 32'h00000518;
			5'd20: val = 32'h0000028C;
			5'd21: val = 32'h00000146;
			5'd22: val = 32'h000000A3;
			5'd23: val = 32'h00000051;
			default: val = 32'h00000000;
		endcase
		return val;
	endfunction

endpackage

[rtl/dro_cordic.sv]
// Iterative CORDIC rotation unit: one shift-add step per cycle while ctl.step is set.
module dro_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dro_pkg::dro_cordic_ctl_t            ctl,
	input  logic signed [dro_pkg::CX_W-1:0]     x_init,
	input  logic [31:0]                         angle_init,
	output logic signed [dro_pkg::CX_W-1:0]     x_result,
	output logic signed [dro_pkg::CX_W-1:0]     y_result,
	output logic                                last
);
	import dro_pkg::*;

	logic signed [CX_W-1:0] cx_q, cy_q, cx_nx, cy_nx, xs, ys;
	logic [31:0] ca_q, ca_nx, atan_v;
	logic [ITER_W-1:0] iter_q;

	// Rotate toward zero residual angle.
	always_comb begin
		xs = cx_q >>> iter_q;
		ys = cy_q >>> iter_q;
		atan_v = dro_atan(5'(iter_q));
		if (ca_q[31]) begin
			cx_nx = cx_q + ys;
			cy_nx = cy_q - xs;
			ca_nx = ca_q + atan_v;
		end else begin
			cx_nx = cx_q - ys;
			cy_nx = cy_q + xs;
			ca_nx = ca_q - atan_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cx_q <= x_init;
			cy_q <= '0;
			ca_q <= angle_init;
		end else if (ctl.step) begin
			cx_q <= cx_nx;
			cy_q <= cy_nx;
			ca_q <= ca_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (ctl.load) begin
			iter_q <= '0;
		end else if (ctl.step) begin
			iter_q <= iter_q + 1'b1;
		end
	end

	assign last = (iter_q == ITER_W'(ROT_STEPS - 1));
	assign x_result = cx_q;
	assign y_result = cy_q;

endmodule

[rtl/dead_reckoning_odometry_top.sv]
// Top level of the dead-reckoning odometry block: sequencer, pose state, APB registers.
//
// Input channel (in_valid, in_stall, in_data) carries one item: an opcode with
// encoder distance, gyro angle and a pose for the set-pose command. Output
// channel (out_valid, out_stall, out_data) returns one item per input item: the
// pose, uncertainty and travelled distance after that item.
// An update that moves the pose runs: one multiply for the start vector, the fold
// step, CORDIC_STEPS rotation steps on the iterative shift-add unit, one multiply
// for the uncertainty growth and the commit step, in that order (MULK, PREP, ROT,
// MULC, DONE). Set pose, the first update and updates inside the deadbands commit
// in the cycle after accept.
// One item is in work at a time: in_stall is high from the cycle after accept
// through the commit cycle, and the sequencer returns to idle before it takes
// the next item, so the sustained rate of moving updates is set by the iterative
// rotation loop.
// The output register holds its item while out_stall is high; a finished item
// waits in the commit cycle until the register is free, and the next input item
// is taken in the cycle after the commit.
// Reset clears the pose, totals, stored readings and initialized flag and loads
// register defaults (distance deadband 3, angle deadband 2, rate 655). Registers
// sit at byte addresses 0, 4 and 8, to be written while idle; no check enforces it.
module dead_reckoning_odometry_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  dro_pkg::dro_in_t    in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dro_pkg::dro_out_t   out_data
);
	import dro_pkg::*;

	// Configuration registers
	logic [7:0]  dist_db_q, ang_db_q;
	logic [15:0] rate_q;
	logic        cfg_wr;

	// Architectural state
	logic [31:0]        last_dist_q;
	logic [15:0]        last_ang_q;
	logic [15:0]        head_q;
	logic signed [31:0] x_q, y_q;
	logic [31:0]        unc_q, trav_q;
	logic               init_q;

	// Item in work
	dro_state_t  state_q, state_nx;
	dro_kind_t   kind_q, kind_a;
	dro_in_t     cmd_q;
	logic [31:0] dmag_q, dmag_a, dd_a, mid_q, mid_a;
	logic        dneg_q;
	logic [15:0] da_q, da_a;
	logic        aneg_a, quiet_a;
	logic [16:0] amag_a;
	logic        in_accept;

	// Shared multiplier and rounding
	logic [31:0] mul_b;
	logic [63:0] prod, prod_q, prod_rnd;
	logic        mul_en;

	// CORDIC interface
	dro_cordic_ctl_t        cordic_ctl;
	logic signed [CX_W-1:0] x_init, x_res, y_res, xmag, xr, yr;
	logic [31:0]            angle_init;
	logic                   fold, cordic_last;
	logic signed [DX_W-1:0] dx_q, dy_q;

	// Commit
	logic               out_free, commit, round_en;
	logic signed [DX_W:0] sx, sy;
	logic signed [31:0] x_nx, y_nx;
	logic [15:0]        head_nx;
	logic [31:0]        unc_nx, trav_nx, inc;
	logic [32:0]        tsum, usum;
	dro_out_t           out_q;
	logic               out_valid_q;

	// APB: always ready, decode on the word address.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_DIST_DB:   prdata = {24'b0, dist_db_q};
			REG_ANG_DB:    prdata = {24'b0, ang_db_q};
			REG_CONF_RATE: prdata = {16'b0, rate_q};
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_db_q <= 8'd3;
			ang_db_q  <= 8'd2;
			rate_q    <= 16'd655;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_DIST_DB:   dist_db_q <= pwdata[7:0];
				REG_ANG_DB:    ang_db_q  <= pwdata[7:0];
				REG_CONF_RATE: rate_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Deltas against the stored readings; the half-turn delta counts as positive.
	always_comb begin
		dd_a   = in_data.distance_reading - last_dist_q;
		dmag_a = dd_a[31] ? (32'd0 - dd_a) : dd_a;
		da_a   = in_data.angle_reading - last_ang_q;
		aneg_a = (da_a > 16'h8000);
		amag_a = aneg_a ? (17'h10000 - {1'b0, da_a}) : {1'b0, da_a};
		mid_a  = aneg_a ? ({head_q, 16'b0} - {amag_a[16:0], 15'b0})
		                : ({head_q, 16'b0} + {amag_a[16:0], 15'b0});
		quiet_a = (dmag_a < {24'b0, dist_db_q}) && (amag_a < {9'b0, ang_db_q});
		if (in_data.opcode == OP_SET_POSE || !init_q) begin
			kind_a = KIND_LOAD;
		end else if (quiet_a) begin
			kind_a = KIND_SKIP;
		end else begin
			kind_a = KIND_MOVE;
		end
	end

	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q  <= in_data;
			kind_q <= kind_a;
			dmag_q <= dmag_a;
			dneg_q <= dd_a[31];
			da_q   <= da_a;
			mid_q  <= mid_a;
		end
	end

	// Sequencer
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_accept) begin
				state_nx = (kind_a == KIND_MOVE) ? ST_MULK : ST_DONE;
			end
			ST_MULK: state_nx = ST_PREP;
			ST_PREP: state_nx = ST_ROT;
			ST_ROT:  if (cordic_last) begin
				state_nx = ST_MULC;
			end
			ST_MULC: state_nx = ST_DONE;
			ST_DONE: if (out_free) begin
				state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall        = (state_q != ST_IDLE);
		cordic_ctl.load = (state_q == ST_PREP);
		cordic_ctl.step = (state_q == ST_ROT);
		mul_en          = (state_q == ST_MULK) || (state_q == ST_MULC);
		round_en        = (state_q == ST_MULC);
		commit          = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// One multiplier: inverse gain for the start vector, then the rate.
	assign mul_b    = (state_q == ST_MULK) ? INV_GAIN : {16'b0, rate_q};
	assign prod     = {32'b0, dmag_q} * {32'b0, mul_b};
	assign prod_rnd = prod_q + 64'h8000;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= prod;
		end
	end

	// Fold the left half-plane: negate the vector and turn by a half turn.
	always_comb begin
		xmag       = {{(CX_W - 48){1'b0}}, prod_rnd[63:16]};
		fold       = mid_q[31] ^ mid_q[30];
		x_init     = (dneg_q ^ fold) ? -xmag : xmag;
		angle_init = fold ? (mid_q ^ 32'h80000000) : mid_q;
	end

	dro_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cordic_ctl),
		.x_init     (x_init),
		.angle_init (angle_init),
		.x_result   (x_res),
		.y_result   (y_res),
		.last       (cordic_last)
	);

	// Round the rotated vector to whole units, halves up.
	assign xr = x_res + CX_W'(32768);
	assign yr = y_res + CX_W'(32768);

	always_ff @(posedge clk) begin
		if (round_en) begin
			dx_q <= xr[CX_W-1:16];
			dy_q <= yr[CX_W-1:16];
		end
	end

	// Next pose and totals.
	always_comb begin
		sx      = {{(DX_W - 31){x_q[31]}}, x_q} + {dx_q[DX_W-1], dx_q};
		sy      = {{(DX_W - 31){y_q[31]}}, y_q} + {dy_q[DX_W-1], dy_q};
		inc     = prod_rnd[47:16];
		tsum    = {1'b0, trav_q} + {1'b0, dmag_q};
		usum    = {1'b0, unc_q} + {1'b0, inc};
		x_nx    = x_q;
		y_nx    = y_q;
		head_nx = head_q;
		unc_nx  = unc_q;
		trav_nx = trav_q;
		unique case (kind_q)
			KIND_LOAD: begin
				if (cmd_q.opcode == OP_SET_POSE) begin
					x_nx    = cmd_q.pose_x;
					y_nx    = cmd_q.pose_y;
					head_nx = cmd_q.pose_heading;
				end else begin
					x_nx    = '0;
					y_nx    = '0;
					head_nx = '0;
				end
				unc_nx  = '0;
				trav_nx = '0;
			end
			KIND_MOVE: begin
				if (sx[DX_W:31] == {(DX_W - 30){sx[DX_W]}}) begin
					x_nx = sx[31:0];
				end else begin
					x_nx = sx[DX_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
				end
				if (sy[DX_W:31] == {(DX_W - 30){sy[DX_W]}}) begin
					y_nx = sy[31:0];
				end else begin
					y_nx = sy[DX_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
				end
				head_nx = head_q + da_q;
				trav_nx = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
				unc_nx  = usum[32] ? 32'hFFFFFFFF : usum[31:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dist_q <= '0;
			last_ang_q  <= '0;
			head_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			unc_q       <= '0;
			trav_q      <= '0;
			init_q      <= 1'b0;
		end else if (commit) begin
			last_dist_q <= cmd_q.distance_reading;
			last_ang_q  <= cmd_q.angle_reading;
			head_q      <= head_nx;
			x_q         <= x_nx;
			y_q         <= y_nx;
			unc_q       <= unc_nx;
			trav_q      <= trav_nx;
			init_q      <= 1'b1;
		end
	end

	// Output register: load on commit, drop when taken.
	always_ff @(posedge clk) begin
		if (commit) begin
			out_q.x_position       <= x_nx;
			out_q.y_position       <= y_nx;
			out_q.heading_estimate <= head_nx;
			out_q.uncertainty      <= unc_nx;
			out_q.travelled        <= trav_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[tb/dro_odometry_checker.sv]
// Checker for the odometry block: predicts each pose from accepted items and compares results.
`timescale 1ns / 100ps

module dro_odometry_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	input  logic                in_valid,
	input  logic                in_stall,
	input  dro_pkg::dro_in_t    in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  dro_pkg::dro_out_t   out_data,
	output int                  mismatches,
	output int                  poses_due
);
	import dro_pkg::*;

	localparam logic [31:0] INV_K = 32'h9B74EDA8;

	// Register copies.
	logic [7:0]  dist_band;
	logic [7:0]  ang_band;
	logic [15:0] growth_rate;

	// Pose tracking state.
	logic [31:0]        prev_dist;
	logic [15:0]        prev_ang;
	logic [15:0]        heading;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [31:0]        uncert;
	logic [31:0]        trav;
	logic               tracking;

	dro_out_t    pending_poses [$];
	logic [31:0] atan_lut [24];

	initial begin
		atan_lut = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
			32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
		};
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		$display("%0t odometry mismatch on %s: got %h, want %h", $time, what, got, want);
	endtask

	// Rotate a signed distance by a heading of 2^32 units per turn, rounded to whole units.
	task automatic rotate_by_heading(input logic [31:0] dist_mag, input logic dist_neg,
		input logic [31:0] ang_in, output logic signed [63:0] dx,
		output logic signed [63:0] dy);
		logic [63:0]        prod;
		logic signed [63:0] cx;
		logic signed [63:0] cy;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		logic [31:0]        ang;
		logic [31:0]        probe;
		int                 i;
		prod = {32'd0, dist_mag} * {32'd0, INV_K};
		cx = (prod + 64'd32768) >> 16;
		cy = '0;
		ang = ang_in;
		if (dist_neg)
			cx = -cx;
		probe = ang + 32'h40000000;
		if (probe[31]) begin
			ang = ang ^ 32'h80000000;
			cx = -cx;
		end
		for (i = 0; i < ROT_STEPS; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (ang[31]) begin
				cx = cx + ys;
				cy = cy - xs;
				ang = ang + atan_lut[i];
			end else begin
				cx = cx - ys;
				cy = cy + xs;
				ang = ang - atan_lut[i];
			end
		end
		dx = (cx + 64'sd32768) >>> 16;
		dy = (cy + 64'sd32768) >>> 16;
	endtask

	task automatic advance_pose(input dro_in_t item, output dro_out_t pose);
		logic [31:0]        dist_step;
		logic [31:0]        dist_mag;
		logic [31:0]        mid;
		logic [15:0]        ang_step;
		logic [15:0]        ang_mag;
		logic               dist_neg;
		logic               ang_neg;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic signed [63:0] sum_x;
		logic signed [63:0] sum_y;
		logic [63:0]        wide;
		if (item.opcode == OP_SET_POSE || !tracking) begin
			// Set pose, or the first update that anchors a zero pose.
			pos_x = (item.opcode == OP_SET_POSE) ? item.pose_x : '0;
			pos_y = (item.opcode == OP_SET_POSE) ? item.pose_y : '0;
			heading = (item.opcode == OP_SET_POSE) ? item.pose_heading : '0;
			uncert = '0;
			trav = '0;
			tracking = 1'b1;
		end else begin
			dist_step = item.distance_reading - prev_dist;
			ang_step = item.angle_reading - prev_ang;
			dist_neg = dist_step[31];
			dist_mag = dist_neg ? -dist_step : dist_step;
			ang_neg = ang_step > 16'h8000;
			ang_mag = ang_neg ? -ang_step : ang_step;
			if (!(dist_mag < {24'd0, dist_band} && ang_mag < {8'd0, ang_band})) begin
				mid = {heading, 16'h0000};
				if (ang_neg)
					mid = mid - ({16'd0, ang_mag} << 15);
				else
					mid = mid + ({16'd0, ang_mag} << 15);
				rotate_by_heading(dist_mag, dist_neg, mid, dx, dy);
				sum_x = pos_x;
				sum_y = pos_y;
				sum_x = sum_x + dx;
				sum_y = sum_y + dy;
				if (sum_x > 64'sd2147483647)
					pos_x = 32'sh7FFFFFFF;
				else if (sum_x < -64'sd2147483648)
					pos_x = 32'sh80000000;
				else
					pos_x = sum_x[31:0];
				if (sum_y > 64'sd2147483647)
					pos_y = 32'sh7FFFFFFF;
				else if (sum_y < -64'sd2147483648)
					pos_y = 32'sh80000000;
				else
					pos_y = sum_y[31:0];
				heading = heading + ang_step;
				wide = {32'd0, trav} + {32'd0, dist_mag};
				trav = (wide > 64'h00000000FFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
				wide = {32'd0, dist_mag} * {48'd0, growth_rate};
				wide = ((wide + 64'd32768) >> 16) + {32'd0, uncert};
				uncert = (wide > 64'h00000000FFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
			end
		end
		prev_dist = item.distance_reading;
		prev_ang = item.angle_reading;
		pose.x_position = pos_x;
		pose.y_position = pos_y;
		pose.heading_estimate = heading;
		pose.uncertainty = uncert;
		pose.travelled = trav;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dro_out_t want;
		dro_out_t pose;
		if (!arst_n) begin
			dist_band = 8'd3;
			ang_band = 8'd2;
			growth_rate = 16'd655;
			prev_dist = '0;
			prev_ang = '0;
			heading = '0;
			pos_x = '0;
			pos_y = '0;
			uncert = '0;
			trav = '0;
			tracking = 1'b0;
			pending_poses.delete();
			poses_due = 0;
		end else begin
			// Results first: a result at this edge belongs to an earlier item.
			if (out_valid && !out_stall) begin
				if (pending_poses.size() == 0) begin
					report_mismatch("result with no item pending", out_data.x_position, '0);
				end else begin
					want = pending_poses.pop_front();
					if (out_data.x_position !== want.x_position)
						report_mismatch("x_position", out_data.x_position, want.x_position);
					if (out_data.y_position !== want.y_position)
						report_mismatch("y_position", out_data.y_position, want.y_position);
					if (out_data.heading_estimate !== want.heading_estimate)
						report_mismatch("heading_estimate",
							32'(out_data.heading_estimate),
							32'(want.heading_estimate));
					if (out_data.uncertainty !== want.uncertainty)
						report_mismatch("uncertainty", out_data.uncertainty, want.uncertainty);
					if (out_data.travelled !== want.travelled)
						report_mismatch("travelled", out_data.travelled, want.travelled);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_DIST_DB: dist_band = pwdata[7:0];
					REG_ANG_DB: ang_band = pwdata[7:0];
					REG_CONF_RATE: growth_rate = pwdata[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				advance_pose(in_data, pose);
				pending_poses.push_back(pose);
			end
			poses_due = pending_poses.size();
		end
	end

endmodule

[tb/tb_dead_reckoning_odometry_top.sv]
// Testbench top for the odometry block: clock, reset, register writes, item stimulus, verdict.
`timescale 1ns / 100ps

module tb_dead_reckoning_odometry_top;
	import dro_pkg::*;

	// Index that decodes to no register; writes to it must leave everything alone.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE = 356;
	localparam int HOLD_CYCLES = 400;
	// Slowest run: about 1800 items, each with its block time, longest gap and longest
	// stall, plus the hold-off and the config phases; allow several times that.
	localparam int CYCLE_LIMIT = 800000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	dro_in_t     in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	dro_out_t    out_data;

	int mismatches;
	int poses_due;
	int cycle_count = 0;

	// Sensor model: cumulative readings that the stimulus advances.
	logic [31:0] cum_dist = '0;
	logic [15:0] cum_ang = '0;

	bit quiet_send = 1'b0;
	bit quiet_recv = 1'b0;
	bit hold_request = 1'b0;

	dead_reckoning_odometry_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	dro_odometry_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.mismatches (mismatches),
		.poses_due  (poses_due)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dead_reckoning_odometry_top regression: fail");
			$finish;
		end
	end

	// Register write: setup cycle, access cycle, then release the bus before returning,
	// so back-to-back writes never touch psel twice in one step.
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one item after a random gap and hold it until the block takes it.
	task automatic offer_item(input dro_in_t item);
		int gap;
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet_send || roll < 60)
			gap = 0;
		else if (roll < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(4, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Advance the sensors and send an update; pose fields carry noise the block must ignore.
	task automatic drive_motion(input logic [31:0] dist_step, input logic [15:0] ang_step);
		dro_in_t item;
		cum_dist = cum_dist + dist_step;
		cum_ang = cum_ang + ang_step;
		item.opcode = OP_UPDATE;
		item.distance_reading = cum_dist;
		item.angle_reading = cum_ang;
		item.pose_x = $urandom;
		item.pose_y = $urandom;
		item.pose_heading = 16'($urandom);
		offer_item(item);
	endtask

	task automatic drive_pose(input logic [31:0] px, input logic [31:0] py,
		input logic [15:0] ph);
		dro_in_t item;
		item.opcode = OP_SET_POSE;
		item.distance_reading = cum_dist;
		item.angle_reading = cum_ang;
		item.pose_x = px;
		item.pose_y = py;
		item.pose_heading = ph;
		offer_item(item);
	endtask

	// Drop valid and let every outstanding pose come back before touching registers.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (poses_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: random stalls, quiet stretches, and one long hold-off on request.
	initial begin : receiver
		int span;
		int roll;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= 1'b0;
			span = quiet_recv ? $urandom_range(50, 200) : $urandom_range(1, 6);
			repeat (span) @(posedge clk);
			if (!quiet_recv) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					span = $urandom_range(1, 3);
				else if (roll < 95)
					span = $urandom_range(4, 10);
				else
					span = $urandom_range(11, 40);
				out_stall <= 1'b1;
				repeat (span) @(posedge clk);
			end
			if ($urandom_range(0, 9) == 0)
				quiet_recv = ~quiet_recv;
		end
	end

	initial begin : stimulus
		int phase;
		int k;
		int roll;
		logic [31:0] px;
		logic [31:0] py;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset deadbands (distance 3, angle 2).
		// First update after reset anchors a zero pose and does not move.
		drive_motion(32'h12345678, 16'hABCD);
		drive_motion(32'h00000000, 16'h0000);
		// Inside both deadbands, forward and backward: readings stored only.
		drive_motion(32'd2, 16'h0001);
		drive_motion(32'hFFFFFFFE, 16'hFFFF);
		// Distance exactly at its deadband moves; pure turn at its deadband too.
		drive_motion(32'd3, 16'h0000);
		drive_motion(32'd0, 16'd2);
		drive_motion(32'd1000, 16'h4000);
		drive_motion(32'hFFFFFC18, 16'hC000);
		// Half-turn delta counts positive; one past it is negative.
		drive_motion(32'd5000, 16'h8000);
		drive_motion(32'd5000, 16'h8001);
		// Largest forward and backward distance deltas.
		drive_motion(32'h7FFFFFFF, 16'h0000);
		drive_motion(32'h80000000, 16'h1234);
		// Clamp x at the top, then at the bottom; clamp y at the top.
		drive_pose(32'h7FFFFF00, 32'h80000100, 16'h0000);
		drive_motion(32'h40000000, 16'h0000);
		drive_motion(32'h40000000, 16'h8000);
		drive_pose(32'h80000000, 32'h7FFFFFFF, 16'h8000);
		drive_motion(32'h7FFFFFFF, 16'h0000);
		drive_pose(32'h00000000, 32'h7FFFFFF0, 16'h4000);
		drive_motion(32'h10000000, 16'h0000);
		// Fresh pose, then big moves until the travelled total clamps.
		drive_pose(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		drive_motion(32'h7FFFFFFF, 16'h7FFF);
		drive_motion(32'h7FFFFFFF, 16'h0000);
		drive_motion(32'h7FFFFFFF, 16'h0000);
		// Set pose with all-ones readings captured as the new reference.
		cum_dist = 32'hFFFFFFFF;
		cum_ang = 16'hFFFF;
		drive_pose(32'h55555555, 32'hAAAAAAAA, 16'h5A5A);
		wait_idle();

		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				1: begin
					// Zero deadbands never ignore; zero rate never grows uncertainty.
					write_reg(REG_DIST_DB, 32'd0);
					write_reg(REG_ANG_DB, 32'd0);
					write_reg(REG_CONF_RATE, 32'd0);
					hold_request = 1'b1;
				end
				2: begin
					write_reg(REG_DIST_DB, 32'd255);
					write_reg(REG_ANG_DB, 32'd255);
					write_reg(REG_CONF_RATE, 32'd65535);
				end
				3: begin
					// Full random words: only the low bits of each register count.
					write_reg(REG_DIST_DB, $urandom);
					write_reg(REG_ANG_DB, $urandom);
					write_reg(REG_CONF_RATE, $urandom);
				end
				4: begin
					write_reg(REG_UNUSED, $urandom);
					write_reg(REG_DIST_DB, 32'd1);
					write_reg(REG_ANG_DB, 32'd1);
					write_reg(REG_CONF_RATE, 32'd1);
				end
				default: ;
			endcase

			for (k = 0; k < RANDOM_PER_PHASE; k++) begin
				if ($urandom_range(0, 49) == 0)
					quiet_send = ~quiet_send;
				roll = $urandom_range(0, 99);
				if (roll < 30) begin
					// Creeping motion around the deadbands.
					drive_motion($urandom_range(0, 600) - 300,
						16'($urandom_range(0, 600) - 300));
				end else if (roll < 65) begin
					drive_motion($urandom_range(0, 131072) - 65536,
						16'($urandom_range(0, 8192) - 4096));
				end else if (roll < 75) begin
					drive_motion($urandom, 16'($urandom));
				end else if (roll < 80) begin
					drive_motion($urandom_range(0, 20000) - 10000, 16'h8000);
				end else if (roll < 84) begin
					if ($urandom_range(0, 1))
						drive_motion(32'd0, 16'($urandom_range(0, 16) - 8));
					else
						drive_motion($urandom_range(0, 6) - 3, 16'h0000);
				end else if (roll < 92) begin
					cum_dist = $urandom;
					cum_ang = 16'($urandom);
					drive_pose($urandom, $urandom, 16'($urandom));
				end else begin
					// Start near a rail so later motion drives x or y into the clamp.
					px = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 4095)
						: 32'h80000000 + $urandom_range(0, 4095);
					py = $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 4095)
						: 32'h80000000 + $urandom_range(0, 4095);
					drive_pose(px, py, 16'($urandom));
				end
			end
			wait_idle();
		end

		repeat (32) @(posedge clk);
		if (mismatches == 0 && poses_due == 0)
			$display("dead_reckoning_odometry_top regression: pass");
		else
			$display("dead_reckoning_odometry_top regression: fail");
		$finish;
	end

endmodule
